/* rtl/core/tdcp_pkg.sv */
// Shared constants and types for the TDC edge pairing block.
// Edge word bit layout, field widths and the stage-one item record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdcp_pkg;

  localparam int unsigned TIME_W   = 16;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned TDC_CH_W = 7;
  localparam int unsigned WORD_W   = 32;

  localparam int unsigned TDC_CH_LSB  = 19;
  localparam int unsigned TRAIL_BIT   = 26;
  localparam int unsigned BOARD1_BIT  = 28;
  localparam int unsigned BOARD2_BIT  = 29;
  localparam int unsigned INVALID_BIT = 31;

  localparam logic [TIME_W-1:0] THRESH_RESET = 16'd3000;

  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // decoded edge word as it travels through the lookup stage
  typedef struct packed {
    logic              clear;
    logic              invalid;
    logic              conflict;
    logic              in_range;
    logic              trailing;
    logic [TIME_W-1:0] t;
    logic [CHAN_W-1:0] chan;
  } tdcp_item_t;

endpackage

`default_nettype wire

/* rtl/core/tdcp_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-first on an address collision. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tdcp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tdc_edge_pairing.sv */
// Top level of the TDC edge pairing block: decode, per-channel lookup, output beat.
// Depends on tdcp_pkg and tdcp_ram.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries cmd_i and a raw edge_word_i.
//   cmd_i = clear wipes every channel's started mark and previous time.
//   Output channel (out_valid_o/out_ready_i) carries exactly one result beat
//   per input beat, in arrival order.
//   Path: an input beat is registered into the lookup stage, and its result
//   into the output registers, where it is taken while out_ready_i is high.
//   Throughput: one beat per cycle while out_ready_i is high. The figure is set
//   by the per-channel previous-time RAM: read in the accept cycle, modify and
//   write back as the beat leaves the lookup stage, with a one-entry write-forward
//   register covering back-to-back beats on the same channel. Started marks live
//   in flip-flops and all clear together, so a clear beat passes like any other.
//   Reset: all channels are unstarted (previous time reads as zero), the long
//   hit threshold returns to 3000. The threshold is written through cfg_we_i.
//   Stall: while out_ready_i is low the output beat holds, the lookup stage
//   keeps one more beat, and in_ready_o drops once both are full.
`timescale 1ns / 1ps
`default_nettype none

module tdc_edge_pairing
  import tdcp_pkg::*;
#(
  parameter int unsigned BOARD_CHANNELS = 128,
  parameter int unsigned NUM_CHANNELS   = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [TIME_W-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              cmd_i,
  input  wire logic [WORD_W-1:0] edge_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   hit_valid_o,
  output logic      [CHAN_W-1:0] channel_o,
  output logic      [TIME_W-1:0] hit_start_o,
  output logic      [TIME_W-1:0] hit_end_o,
  output logic                   long_hit_o,
  output logic                   order_error_o,
  output logic                   invalid_edge_o,
  output logic                   format_conflict_o
);

  localparam int unsigned IDX_W = $clog2(NUM_CHANNELS);

  logic [TIME_W-1:0] thresh_q;

  // decode
  tdcp_item_t        in_item;
  logic [CHAN_W:0]   mch;
  logic              in_acc;

  always_comb begin
    mch = {1'b0, {(CHAN_W-TDC_CH_W){1'b0}}, edge_word_i[TDC_CH_LSB +: TDC_CH_W]}
        + (edge_word_i[BOARD1_BIT] ? (CHAN_W+1)'(BOARD_CHANNELS) : '0);
    in_item.clear    = (cmd_i == CMD_CLEAR);
    in_item.invalid  = edge_word_i[INVALID_BIT];
    in_item.conflict = (edge_word_i[BOARD1_BIT] == edge_word_i[BOARD2_BIT]);
    in_item.in_range = (mch < (CHAN_W+1)'(NUM_CHANNELS));
    in_item.trailing = edge_word_i[TRAIL_BIT];
    in_item.t        = edge_word_i[TIME_W-1:0];
    in_item.chan     = mch[CHAN_W-1:0];
  end

  // lookup stage
  logic              s1_valid_q;
  tdcp_item_t        s1_q;
  logic              s1_adv;
  logic [IDX_W-1:0]  s1_addr;
  logic [TIME_W-1:0] rd_data;
  logic [NUM_CHANNELS-1:0] started_q;

  // last write, forwarded to the beat that read behind it
  logic              lw_en_q;
  logic [IDX_W-1:0]  lw_addr_q;
  logic [TIME_W-1:0] lw_data_q;

  logic              out_valid_q;

  logic              ram_we;
  logic [TIME_W-1:0] ram_wdata;
  logic              started;
  logic [TIME_W-1:0] prev;
  logic              proc;
  logic              first_trail;
  logic              order_err;
  logic              hit;
  logic [TIME_W-1:0] hit_len;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign s1_addr    = s1_q.chan[IDX_W-1:0];

  tdcp_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_CHANNELS)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (in_item.chan[IDX_W-1:0]),
    .rdata_o (rd_data)
  );

  always_comb begin
    started     = started_q[s1_addr];
    prev        = '0;
    if (started) begin
      prev = (lw_en_q && (lw_addr_q == s1_addr)) ? lw_data_q : rd_data;
    end
    proc        = !s1_q.clear && !s1_q.invalid && s1_q.in_range;
    first_trail = !started && s1_q.trailing;
    order_err   = proc && !first_trail && (s1_q.t < prev);
    hit         = proc && !first_trail && !order_err && s1_q.trailing;
    hit_len     = s1_q.t - prev;
    ram_we      = s1_adv && proc;
    // a first trailing edge only marks the channel; prev is zero there
    ram_wdata   = first_trail ? prev : s1_q.t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= THRESH_RESET;
      s1_valid_q  <= 1'b0;
      started_q   <= '0;
      lw_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        lw_en_q <= ram_we;
        if (s1_q.clear) begin
          started_q <= '0;
        end else if (proc) begin
          started_q[s1_addr] <= 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_item;
    end
    if (ram_we) begin
      lw_addr_q <= s1_addr;
      lw_data_q <= ram_wdata;
    end
    if (s1_adv) begin
      hit_valid_o       <= hit;
      channel_o         <= s1_q.clear ? '0 : s1_q.chan;
      hit_start_o       <= hit ? prev : '0;
      hit_end_o         <= hit ? s1_q.t : '0;
      long_hit_o        <= hit && (hit_len > thresh_q);
      order_error_o     <= order_err;
      invalid_edge_o    <= !s1_q.clear && s1_q.invalid;
      format_conflict_o <= !s1_q.clear && !s1_q.invalid && s1_q.conflict;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  a_hit_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_valid_o |-> !order_error_o && !invalid_edge_o)
    else $error("hit flagged together with an error");

  a_hit_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_valid_o |-> hit_end_o >= hit_start_o)
    else $error("hit ends before it starts");

  a_clear_wipes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_q.clear |=> started_q == '0)
    else $error("started marks survive a clear beat");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_o && !out_ready_i)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

/* tb/tb_tdc_edge_pairing.sv */
// Self-checking testbench for tdc_edge_pairing: directed edge cases, threshold
// sweeps, constrained random edge streams and a long output stall.
// Depends on tdcp_pkg and the tdc_edge_pairing RTL.
`timescale 1ns / 1ps

module tb_tdc_edge_pairing;
  import tdcp_pkg::*;

  localparam int unsigned CPB         = 128;
  localparam int unsigned NCH         = 256;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_ITEMS  = 880;

  typedef struct packed {
    logic              hit;
    logic [CHAN_W-1:0] chan;
    logic [TIME_W-1:0] lead;
    logic [TIME_W-1:0] trail;
    logic              long_hit;
    logic              order_err;
    logic              invalid;
    logic              conflict;
  } hit_rec_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we      = 1'b0;
  logic [TIME_W-1:0] cfg_wdata   = '0;
  logic              in_valid    = 1'b0;
  logic              cmd         = CMD_EDGE;
  logic [WORD_W-1:0] edge_word   = '0;
  logic              out_ready   = 1'b0;

  logic              in_ready;
  logic              out_valid;
  logic              hit_valid;
  logic [CHAN_W-1:0] channel;
  logic [TIME_W-1:0] hit_start;
  logic [TIME_W-1:0] hit_end;
  logic              long_hit;
  logic              order_error;
  logic              invalid_edge;
  logic              format_conflict;

  // predictor state
  logic              ch_started   [NCH];
  logic [TIME_W-1:0] ch_prev_time [NCH];
  logic [TIME_W-1:0] long_thresh;
  hit_rec_t          expected_hits[$];

  // stimulus-side bookkeeping
  logic [TIME_W-1:0] stim_clock [NCH];
  logic [CHAN_W-1:0] chan_pool  [8];
  int unsigned       items_sent;
  int unsigned       beats_seen;
  int unsigned       err_count;
  int unsigned       cycles;
  int unsigned       stall_left;
  int unsigned       hold_cycles_req;
  bit                tx_quiet;
  bit                rx_quiet;

  tdc_edge_pairing #(
    .BOARD_CHANNELS(CPB),
    .NUM_CHANNELS  (NCH)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .cmd_i            (cmd),
    .edge_word_i      (edge_word),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .hit_valid_o      (hit_valid),
    .channel_o        (channel),
    .hit_start_o      (hit_start),
    .hit_end_o        (hit_end),
    .long_hit_o       (long_hit),
    .order_error_o    (order_error),
    .invalid_edge_o   (invalid_edge),
    .format_conflict_o(format_conflict)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor

  function automatic void clear_channels();
    for (int i = 0; i < NCH; i++) begin
      ch_started[i]   = 1'b0;
      ch_prev_time[i] = '0;
    end
  endfunction

  function automatic hit_rec_t predict_pairing(logic c, logic [WORD_W-1:0] w);
    hit_rec_t          r;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] prev;
    logic [8:0]        mch;
    logic              b1;
    logic              b2;
    logic              trailing;
    r        = '0;
    t        = w[TIME_W-1:0];
    b1       = w[BOARD1_BIT];
    b2       = w[BOARD2_BIT];
    trailing = w[TRAIL_BIT];
    mch      = 9'(b1 * CPB) + 9'(w[TDC_CH_LSB +: TDC_CH_W]);
    if (c == CMD_CLEAR) begin
      clear_channels();
      return r;
    end
    r.chan = mch[CHAN_W-1:0];
    if (w[INVALID_BIT]) begin
      r.invalid = 1'b1;
      return r;
    end
    r.conflict = (b1 == b2);
    if (mch < NCH) begin
      if (!ch_started[mch] && trailing) begin
        // a channel's opening trailing edge has no partner
        ch_started[mch] = 1'b1;
      end else begin
        prev            = ch_prev_time[mch];
        ch_started[mch] = 1'b1;
        if (t < prev) begin
          r.order_err = 1'b1;
        end else if (trailing) begin
          r.hit      = 1'b1;
          r.lead     = prev;
          r.trail    = t;
          r.long_hit = ((t - prev) > long_thresh);
        end
        ch_prev_time[mch] = t;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stalls, long hold on request, result checking

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    err_count++;
    $display("mismatch on beat %0d: %s got 0x%0h want 0x%0h", beats_seen, what, got, want);
  endtask

  task automatic check_hit_beat();
    hit_rec_t want;
    hit_rec_t got;
    got = '{hit_valid, channel, hit_start, hit_end, long_hit, order_error,
            invalid_edge, format_conflict};
    if (expected_hits.size() == 0) begin
      report_mismatch("unexpected beat", got, 0);
    end else begin
      want = expected_hits.pop_front();
      if (got.hit != want.hit) report_mismatch("hit_valid", got.hit, want.hit);
      if (got.chan != want.chan) report_mismatch("channel", got.chan, want.chan);
      if (got.lead != want.lead) report_mismatch("hit_start", got.lead, want.lead);
      if (got.trail != want.trail) report_mismatch("hit_end", got.trail, want.trail);
      if (got.long_hit != want.long_hit)
        report_mismatch("long_hit", got.long_hit, want.long_hit);
      if (got.order_err != want.order_err)
        report_mismatch("order_error", got.order_err, want.order_err);
      if (got.invalid != want.invalid)
        report_mismatch("invalid_edge", got.invalid, want.invalid);
      if (got.conflict != want.conflict)
        report_mismatch("format_conflict", got.conflict, want.conflict);
    end
    beats_seen++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) check_hit_beat();
      if (hold_cycles_req != 0) begin
        stall_left      = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!rx_quiet && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side

  // returns with valid still high at the accepting edge
  task automatic send_beat(logic c, logic [WORD_W-1:0] w);
    int unsigned gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    edge_word <= w;
    do @(posedge clk_i); while (!(in_valid && in_ready));
    expected_hits = {expected_hits, predict_pairing(c, w)};
    items_sent++;
  endtask

  // unused word bits get random junk
  function automatic logic [WORD_W-1:0] make_word(logic inv, logic b2, logic b1,
                                                  logic trailing, logic [6:0] tdc,
                                                  logic [TIME_W-1:0] t);
    logic [WORD_W-1:0] w;
    w                          = $urandom();
    w[TIME_W-1:0]              = t;
    w[TDC_CH_LSB +: TDC_CH_W]  = tdc;
    w[TRAIL_BIT]               = trailing;
    w[BOARD1_BIT]              = b1;
    w[BOARD2_BIT]              = b2;
    w[INVALID_BIT]             = inv;
    return w;
  endfunction

  task automatic send_edge(logic [CHAN_W-1:0] ch, logic trailing, logic [TIME_W-1:0] t);
    send_beat(CMD_EDGE, make_word(1'b0, ~ch[7], ch[7], trailing, ch[6:0], t));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [TIME_W-1:0] v);
    wait_idle();
    cfg_we      <= 1'b1;
    cfg_wdata   <= v;
    long_thresh  = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [TIME_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 75) return TIME_W'($urandom_range(0, 4000));
    if (r < 80) return TIME_W'(long_thresh + $urandom_range(0, 1));
    return TIME_W'($urandom());
  endfunction

  // lead/trail pair on one channel, time moving forward (wraps now and then)
  task automatic send_pair(logic [CHAN_W-1:0] ch);
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] len;
    t0  = stim_clock[ch] + TIME_W'($urandom_range(0, 200));
    len = pick_length();
    send_edge(ch, 1'b0, t0);
    send_edge(ch, 1'b1, t0 + len);
    stim_clock[ch] = t0 + len;
  endtask

  task automatic refresh_pool();
    foreach (chan_pool[i]) chan_pool[i] = CHAN_W'($urandom_range(0, NCH - 1));
  endtask

  // ---------------------------------------------------------------------------
  // Tests

  task automatic test_directed_cases();
    send_edge(8'd0, 1'b0, 16'd100);
    send_edge(8'd0, 1'b1, 16'd3101);           // one tick over threshold
    send_edge(8'd0, 1'b0, 16'd5000);
    send_edge(8'd0, 1'b1, 16'd8000);           // exactly at threshold
    send_edge(8'd0, 1'b1, 16'd8000);           // zero-length hit
    send_edge(8'd0, 1'b0, 16'd10);             // goes backwards
    send_edge(8'd5, 1'b1, 16'd200);            // opening trailing edge dropped
    send_edge(8'd5, 1'b1, 16'd300);            // hit from time zero
    send_edge(8'd255, 1'b0, 16'hffff);
    send_edge(8'd255, 1'b1, 16'hffff);
    send_edge(8'd128, 1'b1, 16'd0);
    send_edge(8'd128, 1'b0, 16'd0);
    send_edge(8'd128, 1'b1, 16'hffff);         // full-range hit
    send_beat(CMD_EDGE, 32'hffff_ffff);        // invalid word
    send_beat(CMD_EDGE, make_word(1'b1, 1'b1, 1'b0, 1'b1, 7'd3, 16'd77));
    send_beat(CMD_EDGE, make_word(1'b0, 1'b0, 1'b0, 1'b0, 7'd7, 16'd50));
    send_beat(CMD_EDGE, make_word(1'b0, 1'b1, 1'b1, 1'b1, 7'd7, 16'd60));
    send_beat(CMD_EDGE, 32'h0000_0000);
    send_beat(CMD_CLEAR, 32'hffff_ffff);
    send_edge(8'd0, 1'b1, 16'd20);             // unstarted again after clear
    send_edge(8'd0, 1'b0, 16'd0);
    send_edge(8'd0, 1'b1, 16'd0);
    send_beat(CMD_CLEAR, 32'h0000_0000);
    send_edge(8'd5, 1'b0, 16'd0);
  endtask

  task automatic test_threshold_sweep();
    logic [TIME_W-1:0] settings [5];
    settings = '{16'd0, 16'hffff, 16'd1, TIME_W'($urandom()), THRESH_RESET};
    refresh_pool();
    foreach (settings[i]) begin
      write_threshold(settings[i]);
      repeat (16) send_pair(chan_pool[$urandom_range(0, 7)]);
    end
  endtask

  task automatic test_random_stream();
    int unsigned       target;
    int unsigned       r;
    logic [CHAN_W-1:0] ch;
    logic              b1;
    target = items_sent + RAND_ITEMS;
    while (items_sent < target) begin
      if (items_sent % 100 == 0) refresh_pool();
      if (items_sent % 300 < 3) rx_quiet = ~rx_quiet;
      if (items_sent % 250 < 2) tx_quiet = ~tx_quiet;
      ch = chan_pool[$urandom_range(0, 7)];
      r  = $urandom_range(0, 99);
      if (r < 62) begin
        send_pair(ch);
      end else if (r < 72) begin
        send_edge(ch, 1'($urandom()), TIME_W'($urandom()));
      end else if (r < 82) begin
        send_beat(CMD_EDGE, $urandom());
      end else if (r < 87) begin
        send_beat(CMD_EDGE, make_word(1'b1, 1'($urandom()), ch[7], 1'($urandom()),
                                      ch[6:0], TIME_W'($urandom())));
      end else if (r < 90) begin
        send_beat(CMD_CLEAR, $urandom());
      end else begin
        b1 = 1'($urandom());
        send_beat(CMD_EDGE, make_word(1'b0, b1, b1, 1'($urandom()), ch[6:0],
                                      stim_clock[ch] + 16'd5));
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // output held off long enough that the block fills and drops in_ready
  task automatic test_output_hold();
    wait_idle();
    tx_quiet        = 1'b1;
    rx_quiet        = 1'b1;
    hold_cycles_req = 150;
    refresh_pool();
    repeat (20) send_pair(chan_pool[$urandom_range(0, 1)]);
    wait_idle();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    clear_channels();
    long_thresh = THRESH_RESET;
    foreach (stim_clock[i]) stim_clock[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_threshold_sweep();
    test_output_hold();
    test_random_stream();
    write_threshold(16'hffff);
    test_output_hold();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/tdcp_pkg.sv
rtl/core/tdcp_ram.sv
rtl/core/tdc_edge_pairing.sv
tb/tb_tdc_edge_pairing.sv
